// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/gclp_pkg.sv
// ----------------------------------------------------------------------------
// gclp_pkg
// Widths, character codes, field kinds and the power-of-ten table of the
// G-code line field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gclp_pkg;

   localparam int MODE_W  = 34;
   localparam int COORD_W = 48;
   localparam int MAG_W   = COORD_W - 1;
   localparam int LO_W    = 24;
   localparam int HI_W    = MAG_W - LO_W;
   localparam int POW10_W = 20;

   localparam logic [MAG_W-1:0] COORD_CAP = '1;
   localparam logic [MAG_W-1:0] MODE_CAP  = (MAG_W'(1) << MODE_W) - MAG_W'(1);

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_IDLE = 3'd0;
   localparam kind_type KIND_G    = 3'd1;
   localparam kind_type KIND_X    = 3'd2;
   localparam kind_type KIND_Y    = 3'd3;
   localparam kind_type KIND_H    = 3'd4;
   localparam kind_type KIND_I    = 3'd5;
   localparam kind_type KIND_J    = 3'd6;

   localparam int NUM_COORDS = 5;

   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_NL      = 8'h0a;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7a;
   localparam logic [7:0] CH_CASE    = 8'h20;
   localparam logic [7:0] CH_G       = 8'h47;
   localparam logic [7:0] CH_X       = 8'h58;
   localparam logic [7:0] CH_Y       = 8'h59;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_I       = 8'h49;
   localparam logic [7:0] CH_J       = 8'h4a;

   localparam logic ARC_HEIGHT = 1'b0;
   localparam logic ARC_CENTER = 1'b1;

   function automatic logic [POW10_W-1:0] pow10(input int n);
      logic [POW10_W-1:0] p;
      case (n)
         1:       p = POW10_W'(10);
         2:       p = POW10_W'(100);
         3:       p = POW10_W'(1000);
         4:       p = POW10_W'(10000);
         5:       p = POW10_W'(100000);
         6:       p = POW10_W'(1000000);
         default: p = POW10_W'(1);
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/gclp_channels.sv
// ----------------------------------------------------------------------------
// gclp channels
// Valid/ready channel interfaces for the text input, the line result and
// the configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface gclp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_stream;

   modport source (output valid, output char_byte, output end_of_stream, input ready);
   modport sink   (input valid, input char_byte, input end_of_stream, output ready);
endinterface

interface gclp_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [gclp_pkg::MODE_W-1:0]             mode_number;
   logic signed [gclp_pkg::COORD_W-1:0]     target_x;
   logic signed [gclp_pkg::COORD_W-1:0]     target_y;
   logic signed [gclp_pkg::COORD_W-1:0]     height_value;
   logic signed [gclp_pkg::COORD_W-1:0]     center_x;
   logic signed [gclp_pkg::COORD_W-1:0]     center_y;
   logic                                    closed_by_stream_end;

   modport source (output valid, output mode_number, output target_x, output target_y,
                   output height_value, output center_x, output center_y,
                   output closed_by_stream_end, input ready);
   modport sink   (input valid, input mode_number, input target_x, input target_y,
                   input height_value, input center_x, input center_y,
                   input closed_by_stream_end, output ready);
endinterface

interface gclp_csr_if;
   logic valid;
   logic ready;
   logic arc_variant;

   modport source (output valid, output arc_variant, input ready);
   modport sink   (input valid, input arc_variant, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gcode_line_field_parser.sv
// ----------------------------------------------------------------------------
// gcode_line_field_parser
// Byte-serial G-code word parser: keeps the last G, X, Y, H, I and J values
// and reports them all once per line.
// ----------------------------------------------------------------------------
// Usage
//   req_ch : one text byte per word; end_of_stream set closes a pending line
//            and the byte is ignored.
//   rsp_ch : one word per line, on newline or on end of stream after a
//            partly read line; carries every latched value.
//   csr_ch : writes arc_variant (0: H word, 1: I and J words); always ready,
//            write it only while no line is in flight.
//   Throughput: one byte per cycle while req_ch.ready is high. A line result
//   passes from the byte that closes it through the scan register, two
//   partial products of the fraction scaling, saturate, then sign into the
//   result register.
//   A stalled rsp_ch holds its word; the three pipeline stages keep filling
//   with bytes that close fields or lines, and req_ch.ready drops only when
//   all three stages are full and stage 3 holds the next line result.
//   Reset (synchronous, active high) closes any open field, clears the
//   pending-line flag, zeroes all latched values and selects the H word.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_line_field_parser #(
   parameter int MAX_CHARS   = 10,
   parameter int FRAC_DIGITS = 4
) (
   input  wire         clock,
   input  wire         reset,
   gclp_req_if.sink    req_ch,
   gclp_rsp_if.source  rsp_ch,
   gclp_csr_if.sink    csr_ch
);

`include "assert_macros.svh"

   localparam int MAG_W  = gclp_pkg::MAG_W;
   localparam int MODE_W = gclp_pkg::MODE_W;
   localparam int CRD_W  = gclp_pkg::COORD_W;
   localparam int LO_W   = gclp_pkg::LO_W;
   localparam int HI_W   = gclp_pkg::HI_W;
   localparam int CNT_W  = $clog2(MAX_CHARS + 1);
   localparam int FRAC_W = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
   localparam int POW_W  = $clog2(10 ** FRAC_DIGITS + 1);
   localparam int MAC_W  = MAG_W + 4;
   localparam int SUM_W  = MAG_W + POW_W;

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   logic arc_variant_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arc_variant_ff <= gclp_pkg::ARC_HEIGHT;
      end else if (csr_ch.valid) begin
         arc_variant_ff <= csr_ch.arc_variant;
      end
   end

   // ------------------------------------------------------------------------
   // Field scanner state
   // ------------------------------------------------------------------------
   gclp_pkg::kind_type kind_ff, kind_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [MAG_W-1:0]   accum_ff, accum_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic               point_ff, point_in;
   logic               minus_ff, minus_in;
   logic               pending_ff, pending_in;

   logic               req_ready;
   logic               req_acc;

   logic [7:0]         ch;
   logic [7:0]         ch_up;
   logic               eos;
   logic               is_digit;
   logic [3:0]         digit_val;
   logic               field_open;
   logic [MAG_W-1:0]   cap;
   logic [MAC_W-1:0]   mac_ext;
   logic [MAC_W-1:0]   mac_sum;
   logic [MAG_W-1:0]   mac_res;
   logic               take;
   logic [MAG_W-1:0]   acc_n;
   logic [FRAC_W-1:0]  frac_n;
   logic               point_n;
   logic               minus_n;
   logic [CNT_W-1:0]   count_n;
   logic               full;
   logic               keep;
   logic               byte_free;
   logic               do_commit;
   logic               do_emit;
   gclp_pkg::kind_type open_kind;

   assign ch        = req_ch.char_byte;
   assign eos       = req_ch.end_of_stream;
   assign req_acc   = req_ch.valid && req_ready;
   assign is_digit  = (ch >= gclp_pkg::CH_0) && (ch <= gclp_pkg::CH_9);
   assign digit_val = 4'(ch - gclp_pkg::CH_0);
   assign field_open = (kind_ff != gclp_pkg::KIND_IDLE);
   assign cap = (kind_ff == gclp_pkg::KIND_G) ? gclp_pkg::MODE_CAP : gclp_pkg::COORD_CAP;

   // saturating accum * 10 + digit
   assign mac_ext = MAC_W'(accum_ff);
   assign mac_sum = (mac_ext << 3) + (mac_ext << 1) + MAC_W'(digit_val);
   assign mac_res = (mac_sum > MAC_W'(cap)) ? cap : mac_sum[MAG_W-1:0];

   always_comb begin
      take    = 1'b0;
      acc_n   = accum_ff;
      frac_n  = frac_ff;
      point_n = point_ff;
      minus_n = minus_ff;
      if (field_open && !eos) begin
         if (kind_ff == gclp_pkg::KIND_G) begin
            if (is_digit) begin
               take  = 1'b1;
               acc_n = mac_res;
            end
         end else if (is_digit) begin
            take = 1'b1;
            if (!point_ff) begin
               acc_n = mac_res;
            end else if (int'(frac_ff) < FRAC_DIGITS) begin
               acc_n  = mac_res;
               frac_n = frac_ff + FRAC_W'(1);
            end
         end else if (ch == gclp_pkg::CH_MINUS && count_ff == '0) begin
            take    = 1'b1;
            minus_n = 1'b1;
         end else if (ch == gclp_pkg::CH_DOT && !point_ff) begin
            take    = 1'b1;
            point_n = 1'b1;
         end
      end
   end

   assign count_n   = count_ff + CNT_W'(1);
   assign full      = (count_n >= CNT_W'(MAX_CHARS));
   assign keep      = take && !full;
   assign byte_free = !eos && !take;
   assign do_commit = field_open && (eos || !take || full);
   assign do_emit   = eos ? pending_ff : (byte_free && ch == gclp_pkg::CH_NL);

   assign ch_up = (ch >= gclp_pkg::CH_LOW_A && ch <= gclp_pkg::CH_LOW_Z) ?
                  (ch - gclp_pkg::CH_CASE) : ch;

   always_comb begin
      case (ch_up)
         gclp_pkg::CH_G: open_kind = gclp_pkg::KIND_G;
         gclp_pkg::CH_X: open_kind = gclp_pkg::KIND_X;
         gclp_pkg::CH_Y: open_kind = gclp_pkg::KIND_Y;
         gclp_pkg::CH_H: open_kind = (arc_variant_ff == gclp_pkg::ARC_HEIGHT) ?
                                     gclp_pkg::KIND_H : gclp_pkg::KIND_IDLE;
         gclp_pkg::CH_I: open_kind = (arc_variant_ff == gclp_pkg::ARC_CENTER) ?
                                     gclp_pkg::KIND_I : gclp_pkg::KIND_IDLE;
         gclp_pkg::CH_J: open_kind = (arc_variant_ff == gclp_pkg::ARC_CENTER) ?
                                     gclp_pkg::KIND_J : gclp_pkg::KIND_IDLE;
         default:        open_kind = gclp_pkg::KIND_IDLE;
      endcase
   end

   always_comb begin
      kind_in    = gclp_pkg::KIND_IDLE;
      pending_in = pending_ff;
      if (keep) begin
         kind_in = kind_ff;
      end else if (byte_free) begin
         kind_in    = open_kind;
         pending_in = (ch != gclp_pkg::CH_NL);
      end else if (eos) begin
         pending_in = 1'b0;
      end
      // a freshly opened or closed field starts empty
      count_in = keep ? count_n : '0;
      accum_in = keep ? acc_n   : '0;
      frac_in  = keep ? frac_n  : '0;
      point_in = keep ? point_n : 1'b0;
      minus_in = keep ? minus_n : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= gclp_pkg::KIND_IDLE;
         count_ff   <= '0;
         accum_ff   <= '0;
         frac_ff    <= '0;
         point_ff   <= 1'b0;
         minus_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else if (req_acc) begin
         kind_ff    <= kind_in;
         count_ff   <= count_in;
         accum_ff   <= accum_in;
         frac_ff    <= frac_in;
         point_ff   <= point_in;
         minus_ff   <= minus_in;
         pending_ff <= pending_in;
      end
   end

   // ------------------------------------------------------------------------
   // Commit pipeline: scale, saturate, sign, latch, report
   // ------------------------------------------------------------------------
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic               s1_commit_ff, s2_commit_ff, s3_commit_ff;
   logic               s1_emit_ff, s2_emit_ff, s3_emit_ff;
   logic               s1_end_ff, s2_end_ff, s3_end_ff;
   gclp_pkg::kind_type s1_kind_ff, s2_kind_ff, s3_kind_ff;
   logic               s1_minus_ff, s2_minus_ff, s3_minus_ff;
   logic [MAG_W-1:0]   s1_mag_ff;
   logic [FRAC_W-1:0]  s1_frac_ff;
   logic [HI_W+POW_W-1:0] s2_pp_hi_ff, s2_pp_hi_in;
   logic [LO_W+POW_W-1:0] s2_pp_lo_ff, s2_pp_lo_in;
   logic [MAG_W-1:0]   s3_mag_ff, s3_mag_in;

   logic               s1_free, s2_free, s3_free, s3_done;
   logic [POW_W-1:0]   scale;
   logic [SUM_W-1:0]   pp_sum;

   logic               rsp_valid_ff;

   assign s3_done = s3_valid_ff && (!s3_emit_ff || !rsp_valid_ff || rsp_ch.ready);
   assign s3_free = !s3_valid_ff || s3_done;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign req_ready    = s1_free;
   assign req_ch.ready = req_ready;

   // stage 1 -> 2: split product of magnitude and the missing fraction scale
   assign scale = (s1_kind_ff == gclp_pkg::KIND_G) ? POW_W'(1) :
                  POW_W'(gclp_pkg::pow10(FRAC_DIGITS - int'(s1_frac_ff)));
   assign s2_pp_hi_in = (HI_W+POW_W)'(s1_mag_ff[MAG_W-1:LO_W]) * (HI_W+POW_W)'(scale);
   assign s2_pp_lo_in = (LO_W+POW_W)'(s1_mag_ff[LO_W-1:0]) * (LO_W+POW_W)'(scale);

   // stage 2 -> 3: combine and saturate the magnitude
   assign pp_sum    = {s2_pp_hi_ff, {LO_W{1'b0}}} + SUM_W'(s2_pp_lo_ff);
   assign s3_mag_in = (pp_sum > SUM_W'(gclp_pkg::COORD_CAP)) ? gclp_pkg::COORD_CAP :
                      pp_sum[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_acc && (do_commit || do_emit);
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_acc) begin
         s1_commit_ff <= do_commit;
         s1_emit_ff   <= do_emit;
         s1_end_ff    <= eos;
         s1_kind_ff   <= kind_ff;
         s1_minus_ff  <= minus_n;
         s1_mag_ff    <= acc_n;
         s1_frac_ff   <= frac_n;
      end
      if (s2_free && s1_valid_ff) begin
         s2_commit_ff <= s1_commit_ff;
         s2_emit_ff   <= s1_emit_ff;
         s2_end_ff    <= s1_end_ff;
         s2_kind_ff   <= s1_kind_ff;
         s2_minus_ff  <= s1_minus_ff;
         s2_pp_hi_ff  <= s2_pp_hi_in;
         s2_pp_lo_ff  <= s2_pp_lo_in;
      end
      if (s3_free && s2_valid_ff) begin
         s3_commit_ff <= s2_commit_ff;
         s3_emit_ff   <= s2_emit_ff;
         s3_end_ff    <= s2_end_ff;
         s3_kind_ff   <= s2_kind_ff;
         s3_minus_ff  <= s2_minus_ff;
         s3_mag_ff    <= s3_mag_in;
      end
   end

   // stage 3: apply sign and update the latched words
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CRD_W-1:0]  coords_ff [gclp_pkg::NUM_COORDS];
   logic [CRD_W-1:0]  coords_in [gclp_pkg::NUM_COORDS];
   logic [CRD_W-1:0]  signed_val;

   assign signed_val = s3_minus_ff ? (CRD_W'(0) - CRD_W'(s3_mag_ff)) : CRD_W'(s3_mag_ff);
   assign mode_in = (s3_commit_ff && s3_kind_ff == gclp_pkg::KIND_G) ?
                    s3_mag_ff[MODE_W-1:0] : mode_ff;

   always_comb begin
      for (int i = 0; i < gclp_pkg::NUM_COORDS; i++) begin
         coords_in[i] = (s3_commit_ff && s3_kind_ff == gclp_pkg::KIND_X + 3'(i)) ?
                        signed_val : coords_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         for (int i = 0; i < gclp_pkg::NUM_COORDS; i++) begin
            coords_ff[i] <= '0;
         end
      end else if (s3_done) begin
         mode_ff <= mode_in;
         for (int i = 0; i < gclp_pkg::NUM_COORDS; i++) begin
            coords_ff[i] <= coords_in[i];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   logic              rsp_load;
   logic [MODE_W-1:0] rsp_mode_ff;
   logic [CRD_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_h_ff, rsp_i_ff, rsp_j_ff;
   logic              rsp_end_ff;

   assign rsp_load = s3_done && s3_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mode_ff <= mode_in;
         rsp_x_ff    <= coords_in[0];
         rsp_y_ff    <= coords_in[1];
         rsp_h_ff    <= coords_in[2];
         rsp_i_ff    <= coords_in[3];
         rsp_j_ff    <= coords_in[4];
         rsp_end_ff  <= s3_end_ff;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.mode_number          = rsp_mode_ff;
   assign rsp_ch.target_x             = rsp_x_ff;
   assign rsp_ch.target_y             = rsp_y_ff;
   assign rsp_ch.height_value         = rsp_h_ff;
   assign rsp_ch.center_x             = rsp_i_ff;
   assign rsp_ch.center_y             = rsp_j_ff;
   assign rsp_ch.closed_by_stream_end = rsp_end_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_HOLDS(a_field_len, clock, reset, field_open, count_ff < CNT_W'(MAX_CHARS))
   `ASSERT_HOLDS(a_g_plain, clock, reset, kind_ff == gclp_pkg::KIND_G, !point_ff && !minus_ff)
   `ASSERT_HOLDS(a_frac_point, clock, reset, frac_ff != '0, point_ff)
   `ASSERT_HOLDS(a_stall_full, clock, reset, !req_ready, s1_valid_ff && s2_valid_ff)
   `ASSERT_NEXT(a_emit_held, clock, reset, s3_valid_ff && !s3_done, s3_valid_ff && s3_emit_ff)

endmodule

`default_nettype wire
